// ----- rtl/core/sdep_pkg.sv -----
package sdep_pkg;

   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   localparam int unsigned SENT_LEN   = 6;
   localparam int unsigned PREFIX_LEN = 5;

   localparam logic [2:0] SENT_FULL   = 3'(SENT_LEN);
   localparam logic [2:0] PREFIX_LAST = 3'(PREFIX_LEN - 1);

   // line phase codes
   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_PREFIX = 3'd1;
   localparam logic [2:0] PH_FIRST  = 3'd2;
   localparam logic [2:0] PH_VALUE  = 3'd3;
   localparam logic [2:0] PH_SKIP   = 3'd4;

   // work for one input word: a run of held "[DONE]" characters, then at most one tail word
   typedef struct packed {
      logic [2:0] flush_count;
      logic       tail_valid;
      logic [7:0] tail_byte;
      logic       tail_byte_valid;
      logic       tail_event_end;
      logic       tail_stream_done;
   } job_type;

   function automatic logic [7:0] sentinel_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h5B; // [
         3'd1:    c = 8'h44; // D
         3'd2:    c = 8'h4F; // O
         3'd3:    c = 8'h4E; // N
         3'd4:    c = 8'h45; // E
         3'd5:    c = 8'h5D; // ]
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h64; // d
         3'd1:    c = 8'h61; // a
         3'd2:    c = 8'h74; // t
         3'd3:    c = 8'h61; // a
         3'd4:    c = 8'h3A; // :
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/core/sse_data_event_parser_core.sv -----
// Channel   Ports                                         Direction
// req       req_valid, req_ready, req_byte_in             in  (one stream byte per word)
// rsp       rsp_valid, rsp_ready, rsp_data_byte,          out (data byte, event end or
//           rsp_byte_valid, rsp_event_end, rsp_stream_done     stream done marker)
//
// One byte per cycle while req_ready is high; words go through the job then the output register.
// A byte that releases held "[DONE]" prefix text gives up to seven words, one per
// cycle from the job register unless rsp stalls; req_ready stays low until its last word moves on.
// Synchronous active-high reset returns the parser to line start with no job queued.
// Stalls on rsp backpressure the job register and then req_ready.
module sse_data_event_parser_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_event_end,
   output logic       rsp_stream_done
);
   import sdep_pkg::*;

   job_type job;
   logic    take;

   assign take = req_valid && req_ready;

   sdep_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .byte_in (req_byte_in),
      .job     (job)
   );

   sdep_emitter u_emitter (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .job_new         (job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_event_end   (rsp_event_end),
      .rsp_stream_done (rsp_stream_done)
   );

endmodule

// ----- rtl/core/sdep_parser.sv -----
module sdep_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [7:0]       byte_in,
   output sdep_pkg::job_type job
);
   import sdep_pkg::*;

   logic [2:0] phase_ff, phase_in;
   logic [2:0] pos_ff, pos_in;
   logic       last_cr_ff, last_cr_in;
   logic       has_data_ff, has_data_in;
   logic       sent_poss_ff, sent_poss_in;
   logic [2:0] held_ff, held_in;
   logic       finished_ff, finished_in;

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      last_cr_in   = last_cr_ff;
      has_data_in  = has_data_ff;
      sent_poss_in = sent_poss_ff;
      held_in      = held_ff;
      finished_in  = finished_ff;

      job.flush_count      = 3'd0;
      job.tail_valid       = 1'b0;
      job.tail_byte        = CHAR_NUL;
      job.tail_byte_valid  = 1'b0;
      job.tail_event_end   = 1'b0;
      job.tail_stream_done = 1'b0;

      if (!finished_ff) begin
         last_cr_in = 1'b0;
         if (byte_in == CHAR_LF || byte_in == CHAR_CR) begin
            if (byte_in == CHAR_CR) begin
               last_cr_in = 1'b1;
            end
            // LF straight after CR is swallowed
            if (byte_in == CHAR_CR || !last_cr_ff) begin
               if (phase_ff == PH_START && has_data_ff) begin
                  if (sent_poss_ff && held_ff == SENT_FULL) begin
                     job.tail_valid       = 1'b1;
                     job.tail_stream_done = 1'b1;
                     finished_in          = 1'b1;
                  end else begin
                     job.flush_count    = held_ff;
                     job.tail_valid     = 1'b1;
                     job.tail_event_end = 1'b1;
                  end
                  held_in      = 3'd0;
                  has_data_in  = 1'b0;
                  sent_poss_in = 1'b1;
               end
               phase_in = PH_START;
               pos_in   = 3'd0;
            end
         end else begin
            unique case (phase_ff)
               PH_START, PH_PREFIX: begin
                  if (pos_ff <= PREFIX_LAST && byte_in == prefix_char(pos_ff)) begin
                     if (pos_ff == PREFIX_LAST) begin
                        if (has_data_ff) begin
                           // second data line: flush held text, join with newline
                           job.flush_count     = held_ff;
                           held_in             = 3'd0;
                           sent_poss_in        = 1'b0;
                           job.tail_valid      = 1'b1;
                           job.tail_byte       = CHAR_LF;
                           job.tail_byte_valid = 1'b1;
                        end
                        has_data_in = 1'b1;
                        pos_in      = 3'd0;
                        phase_in    = PH_FIRST;
                     end else begin
                        pos_in   = 3'(pos_ff + 3'd1);
                        phase_in = PH_PREFIX;
                     end
                  end else begin
                     pos_in   = 3'd0;
                     phase_in = PH_SKIP;
                  end
               end
               PH_FIRST, PH_VALUE: begin
                  phase_in = PH_VALUE;
                  if (phase_ff == PH_VALUE || byte_in != CHAR_SPACE) begin
                     if (sent_poss_ff && held_ff < SENT_FULL
                         && byte_in == sentinel_char(held_ff)) begin
                        held_in = 3'(held_ff + 3'd1);
                     end else begin
                        if (sent_poss_ff) begin
                           job.flush_count = held_ff;
                           held_in         = 3'd0;
                           sent_poss_in    = 1'b0;
                        end
                        job.tail_valid      = 1'b1;
                        job.tail_byte       = byte_in;
                        job.tail_byte_valid = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         pos_ff       <= 3'd0;
         last_cr_ff   <= 1'b0;
         has_data_ff  <= 1'b0;
         sent_poss_ff <= 1'b1;
         held_ff      <= 3'd0;
         finished_ff  <= 1'b0;
      end else if (take) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         last_cr_ff   <= last_cr_in;
         has_data_ff  <= has_data_in;
         sent_poss_ff <= sent_poss_in;
         held_ff      <= held_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

// ----- rtl/core/sdep_emitter.sv -----
module sdep_emitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sdep_pkg::job_type job_new,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_event_end,
   output logic              rsp_stream_done
);
   import sdep_pkg::*;

   job_type    job_ff;
   logic       job_valid_ff, job_valid_in;
   logic [2:0] flush_idx_ff, flush_idx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] data_ff, data_in;
   logic       bv_ff, bv_in;
   logic       end_ff, end_in;
   logic       done_ff, done_in;

   logic advance, emit, flushing, job_last, job_free, take, new_nonempty;

   assign advance      = !rsp_valid_ff || rsp_ready;
   assign emit         = job_valid_ff && advance;
   assign flushing     = flush_idx_ff != job_ff.flush_count;
   assign job_last     = flushing ? (3'(flush_idx_ff + 3'd1) == job_ff.flush_count
                                     && !job_ff.tail_valid)
                                  : 1'b1;
   assign job_free     = !job_valid_ff || (emit && job_last);
   assign take         = req_valid && job_free;
   assign new_nonempty = job_new.flush_count != 3'd0 || job_new.tail_valid;

   assign req_ready = job_free;

   always_comb begin
      rsp_valid_in = advance ? job_valid_ff : rsp_valid_ff;
      if (job_free) begin
         job_valid_in = take && new_nonempty;
         flush_idx_in = 3'd0;
      end else begin
         job_valid_in = job_valid_ff;
         flush_idx_in = emit ? 3'(flush_idx_ff + 3'd1) : flush_idx_ff;
      end
      if (flushing) begin
         data_in = sentinel_char(flush_idx_ff);
         bv_in   = 1'b1;
         end_in  = 1'b0;
         done_in = 1'b0;
      end else begin
         data_in = job_ff.tail_byte;
         bv_in   = job_ff.tail_byte_valid;
         end_in  = job_ff.tail_event_end;
         done_in = job_ff.tail_stream_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         flush_idx_ff <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         flush_idx_ff <= flush_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= job_new;
      end
      if (emit) begin
         data_ff <= data_in;
         bv_ff   <= bv_in;
         end_ff  <= end_in;
         done_ff <= done_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_byte   = data_ff;
   assign rsp_byte_valid  = bv_ff;
   assign rsp_event_end   = end_ff;
   assign rsp_stream_done = done_ff;

endmodule

// ----- bench/tb.sv -----
module tb;
   import sdep_pkg::*;

   localparam string DONE_TEXT = "[DONE]";
   localparam string FIELD_TAG = "data:";
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 300;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       event_end;
      logic       stream_done;
   } rsp_word_type;

   // Tracks the parser state and the result words still owed by the block.
   class sse_scoreboard;
      logic [2:0] phase;
      logic [2:0] tag_pos;
      logic [2:0] held;
      bit prev_cr;
      bit have_data;
      bit may_be_done;
      bit finished;
      rsp_word_type expected_q[$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned bytes_seen;
      int unsigned events_closed;

      function new();
         phase = PH_START;
         tag_pos = 0;
         held = 0;
         prev_cr = 0;
         have_data = 0;
         may_be_done = 1;
         finished = 0;
         mismatches = 0;
         checked = 0;
         bytes_seen = 0;
         events_closed = 0;
      endfunction

      function void expect_word(logic [7:0] d, bit v, bit e, bit s);
         rsp_word_type w;
         w.data_byte = d;
         w.byte_valid = v;
         w.event_end = e;
         w.stream_done = s;
         expected_q.push_back(w);
      endfunction

      // held characters are always the leading part of the sentinel
      function void release_held();
         for (int i = 0; i < held; i++) expect_word(DONE_TEXT[i], 1, 0, 0);
         held = 0;
      endfunction

      function void value_char(logic [7:0] b);
         if (may_be_done) begin
            if (held < SENT_LEN && b == DONE_TEXT[held]) begin
               held++;
               return;
            end
            release_held();
            may_be_done = 0;
         end
         expect_word(b, 1, 0, 0);
      endfunction

      function void close_line();
         if (phase == PH_START && have_data) begin
            if (may_be_done && held == SENT_LEN) begin
               expect_word(CHAR_NUL, 0, 0, 1);
               finished = 1;
               held = 0;
            end else begin
               release_held();
               expect_word(CHAR_NUL, 0, 1, 0);
               events_closed++;
            end
            have_data = 0;
            may_be_done = 1;
         end
         phase = PH_START;
         tag_pos = 0;
      endfunction

      function void note_byte(logic [7:0] b);
         bit was_cr;
         if (finished) return;
         bytes_seen++;
         was_cr = prev_cr;
         prev_cr = 0;
         if (b == CHAR_LF) begin
            // LF straight after CR belongs to the same terminator
            if (!was_cr) close_line();
            return;
         end
         if (b == CHAR_CR) begin
            prev_cr = 1;
            close_line();
            return;
         end
         case (phase)
            PH_START, PH_PREFIX: begin
               if (tag_pos < PREFIX_LEN && b == FIELD_TAG[tag_pos]) begin
                  tag_pos++;
                  phase = PH_PREFIX;
                  if (tag_pos == PREFIX_LEN) begin
                     if (have_data) begin
                        release_held();
                        may_be_done = 0;
                        expect_word(CHAR_LF, 1, 0, 0);
                     end
                     have_data = 1;
                     tag_pos = 0;
                     phase = PH_FIRST;
                  end
               end else begin
                  tag_pos = 0;
                  phase = PH_SKIP;
               end
            end
            PH_FIRST: begin
               phase = PH_VALUE;
               if (b != CHAR_SPACE) value_char(b);
            end
            PH_VALUE: value_char(b);
            default: ;
         endcase
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word: data_byte %h byte_valid %b event_end %b stream_done %b",
                     $time, got.data_byte, got.byte_valid, got.event_end, got.stream_done);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got !== want) begin
            mismatches++;
            $display("%0t: mismatch: expected data_byte %h byte_valid %b event_end %b stream_done %b",
                     $time, want.data_byte, want.byte_valid, want.event_end, want.stream_done);
            $display("%0t:           got data_byte %h byte_valid %b event_end %b stream_done %b",
                     $time, got.data_byte, got.byte_valid, got.event_end, got.stream_done);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_byte_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_byte_valid;
   logic       rsp_event_end;
   logic       rsp_stream_done;

   sse_scoreboard sb;
   rsp_word_type seen_word;
   logic [7:0] byte_plan[$];
   bit tx_idle = 1;
   bit rx_idle = 1;
   bit hold_request = 0;

   sse_data_event_parser_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_event_end   (rsp_event_end),
      .rsp_stream_done (rsp_stream_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_byte(req_byte_in);
         if (rsp_valid && rsp_ready) begin
            seen_word = {rsp_data_byte, rsp_byte_valid, rsp_event_end, rsp_stream_done};
            sb.check_word(seen_word);
         end
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (rx_idle && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 12);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timed out with %0d words outstanding", $time, sb.expected_q.size());
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void plan_byte(logic [7:0] b);
      byte_plan.push_back(b);
   endfunction

   function automatic void plan_text(string s);
      for (int i = 0; i < s.len(); i++) byte_plan.push_back(s[i]);
   endfunction

   function automatic void plan_eol();
      case ($urandom_range(0, 2))
         0: plan_byte(CHAR_LF);
         1: plan_byte(CHAR_CR);
         default: begin
            plan_byte(CHAR_CR);
            plan_byte(CHAR_LF);
         end
      endcase
   endfunction

   // one event: a few lines of mixed kinds, then a blank line
   function automatic void plan_event();
      int lines;
      int len;
      int cut;
      int kind;
      bit need_data;
      logic [7:0] b;
      lines = $urandom_range(1, 3);
      need_data = 0;
      for (int l = 0; l < lines; l++) begin
         kind = need_data ? 0 : $urandom_range(0, 9);
         need_data = 0;
         if (kind < 6) begin
            plan_text(FIELD_TAG);
            if ($urandom_range(0, 1)) plan_byte(CHAR_SPACE);
            case ($urandom_range(0, 2))
               0: begin
                  len = $urandom_range(0, SENT_LEN);
                  for (int i = 0; i < len; i++) plan_byte(DONE_TEXT[i]);
                  cut = len;
                  // a bare full sentinel only when another data line follows
                  if (len == SENT_LEN && l < lines - 1 && $urandom_range(0, 1)) begin
                     need_data = 1;
                     len = 0;
                  end else if (len == SENT_LEN) begin
                     len = $urandom_range(1, 3);
                  end else begin
                     len = $urandom_range(0, 3);
                  end
                  for (int i = 0; i < len; i++) begin
                     b = 8'($urandom_range(8'h21, 8'h7E));
                     // a partial prefix must not grow into the full sentinel
                     if (i == 0 && cut < SENT_LEN && b == DONE_TEXT[cut]) b = 8'h7E;
                     plan_byte(b);
                  end
               end
               1: begin
                  len = $urandom_range(0, 8);
                  for (int i = 0; i < len; i++) plan_byte(8'($urandom_range(8'h20, 8'h7E)));
               end
               default: begin
                  len = $urandom_range(1, 6);
                  for (int i = 0; i < len; i++) begin
                     b = 8'($urandom_range(0, 255));
                     if (b == CHAR_LF || b == CHAR_CR) b = b ^ 8'h80;
                     plan_byte(b);
                  end
               end
            endcase
         end else if (kind == 6) begin
            plan_byte(CHAR_COLON);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) plan_byte(8'($urandom_range(8'h20, 8'h7E)));
         end else if (kind == 7) begin
            if ($urandom_range(0, 1)) plan_text("id: 42");
            else plan_text("event:ping");
         end else if (kind == 8) begin
            // tag broken part way through
            len = $urandom_range(1, PREFIX_LEN - 1);
            for (int i = 0; i < len; i++) plan_byte(FIELD_TAG[i]);
            plan_byte(8'($urandom_range(8'h21, 8'h7E)));
            plan_text("xy");
         end else begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 3) == 0) plan_byte($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
               else plan_byte(8'($urandom_range(0, 255)));
            end
         end
         plan_eol();
      end
      plan_eol();
   endfunction

   // called and returns at a falling edge
   task automatic send_byte(logic [7:0] b);
      if (tx_idle && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_plan();
      while (byte_plan.size() != 0) send_byte(byte_plan.pop_front());
   endtask

   task automatic send_events(int unsigned upto);
      while (sb.bytes_seen < upto && !sb.finished) begin
         plan_event();
         send_plan();
      end
   endtask

   initial begin : stimulus
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // comment line holding a NUL, blank line without data, full sentinel
      // broken by 0xFF, CR LF pair, second data line, blank line with data
      plan_byte(CHAR_COLON);
      plan_byte(8'h00);
      plan_byte(CHAR_LF);
      plan_byte(CHAR_LF);
      plan_text("data:[DONE]");
      plan_byte(8'hFF);
      plan_byte(CHAR_CR);
      plan_byte(CHAR_LF);
      plan_text(FIELD_TAG);
      plan_byte(CHAR_CR);
      plan_byte(CHAR_CR);
      send_plan();

      send_events(90);
      hold_request = 1;
      send_events(160);

      // let every owed word out before carrying on
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.expected_q.size() != 0) @(negedge clock);

      send_events(230);
      tx_idle = 0;
      rx_idle = 0;
      send_events(285);

      // close any event left open by a CR then LF blank line, then the sentinel
      // event, then bytes that must be swallowed silently
      plan_byte(CHAR_LF);
      plan_byte(CHAR_LF);
      plan_text("data: [DONE]");
      plan_byte(CHAR_LF);
      plan_byte(CHAR_LF);
      plan_text("data:x");
      plan_byte(CHAR_LF);
      plan_byte(CHAR_LF);
      send_plan();
      req_valid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Parsed %0d stream bytes into %0d checked words over %0d closed events; sentinel %0s.",
               sb.bytes_seen, sb.checked, sb.events_closed, sb.finished ? "seen" : "not seen");
      $display("Mixed line endings, held sentinel prefixes, skipped lines, a long result stall, a drain.");
      if (sb.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
